### hw/rtl/tpdm_pkg.sv
// Shared types and constants for the touch pen detect and map block.
`timescale 1ns / 1ps

package tpdm_pkg;

  localparam int RAW_W      = 12;
  localparam int SIZE_W     = 13;
  localparam int OUT_W      = 12;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int PROD_W     = 25;
  localparam int NUM_W      = 28;
  localparam int REM_W      = 13;
  localparam int QUO_W      = 14;
  localparam int DIGITS     = 7;
  localparam int CNT_W      = 3;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BUS_ERROR = 2'd1;
  localparam status_t ST_BAD_REPLY = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_RAW_X_LOW     = 3'd0;
  localparam cfg_idx_t CFG_RAW_X_HIGH    = 3'd1;
  localparam cfg_idx_t CFG_RAW_Y_LOW     = 3'd2;
  localparam cfg_idx_t CFG_RAW_Y_HIGH    = 3'd3;
  localparam cfg_idx_t CFG_ORIENTATION   = 3'd4;
  localparam cfg_idx_t CFG_SCREEN_WIDTH  = 3'd5;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT = 3'd6;

  localparam logic [RAW_W-1:0] PEN_DOWN_LEVEL = 12'd200;
  localparam logic [RAW_W-1:0] PEN_UP_LEVEL   = 12'd80;
  localparam logic [OUT_W-1:0] OUT_MAX        = 12'd4095;
  localparam logic [NIB_W-1:0] NIBBLE_MASK    = 4'hF;

  typedef struct packed {
    logic [RAW_W-1:0] n;
    logic [RAW_W-1:0] d;
  } frac_t;

endpackage

### hw/rtl/touch_pen_detect_and_map.sv
// Top level: pen detection with hysteresis and calibrated screen mapping.
`timescale 1ns / 1ps

// One touch request is taken at a time. A request with a bus error, a bad
// pressure nibble, a bad coordinate nibble while pressed, or a released pen
// goes straight from acceptance to S_FIN, which loads its result into the
// output register once that register is free. A pressed request runs a
// digit-serial sequencer that handles both axes side by side: a multiply two
// bits per cycle (S_MUL), a state to form the numerator (S_PREP), a restoring
// divide two quotient bits per cycle (S_DIV) and a clamp state (S_DONE). The next request is taken the
// cycle after the result is loaded into the output register, even while that
// result still waits for out_ready. Configuration writes are always ready.
module touch_pen_detect_and_map
  import tpdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  bus_error,
  input  logic [BYTE_W-1:0]     pressure_hi,
  input  logic [BYTE_W-1:0]     pressure_lo,
  input  logic [BYTE_W-1:0]     xpos_hi,
  input  logic [BYTE_W-1:0]     xpos_lo,
  input  logic [BYTE_W-1:0]     ypos_hi,
  input  logic [BYTE_W-1:0]     ypos_lo,
  output logic                  out_valid,
  input  logic                  out_ready,
  output status_t               status,
  output logic                  pen_down,
  output logic [OUT_W-1:0]      screen_x,
  output logic [OUT_W-1:0]      screen_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_PREP,
    S_DIV,
    S_DONE,
    S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RAW_W-1:0]  raw_x_low, raw_x_high, raw_y_low, raw_y_high;
  logic [2:0]        orientation;
  logic [SIZE_W-1:0] screen_width, screen_height;

  // Touch state.
  logic              was_pressed;
  logic [OUT_W-1:0]  held_x, held_y;

  // Pending result, waiting for the output register.
  status_t           res_status;
  logic              res_pen;
  logic [OUT_W-1:0]  res_x, res_y;

  // Per-axis sequencer registers; lane 0 is X, lane 1 is Y.
  logic [RAW_W-1:0]  n_reg  [2];
  logic [RAW_W-1:0]  d_reg  [2];
  logic [QUO_W-1:0]  mul_sr [2];
  logic [PROD_W-1:0] acc    [2];
  logic [REM_W-1:0]  dvs    [2];
  logic [REM_W-1:0]  rem    [2];
  logic [QUO_W-1:0]  low_sr [2];
  logic [QUO_W-1:0]  quo    [2];
  logic [OUT_W-1:0]  limit  [2];
  logic [CNT_W-1:0]  cnt;

  // Accept-path decode.
  logic [RAW_W-1:0]  z1, rx, ry;
  logic              z_bad, xy_bad, pen_now;
  frac_t             fx, fy;
  frac_t             fs   [2];
  frac_t             fm   [2];
  logic [SIZE_W-1:0] size [2];
  logic [OUT_W-1:0]  lim_in [2];

  // Sequencer step logic.
  logic [PROD_W-1:0]  acc_next [2];
  logic [NUM_W-1:0]   num      [2];
  logic [REM_W+1:0]   rem4     [2];
  logic [REM_W+1:0]   dm1      [2];
  logic [REM_W+1:0]   dm2      [2];
  logic [REM_W+1:0]   dm3      [2];
  logic [REM_W+1:0]   sub      [2];
  logic [1:0]         qdig     [2];
  logic [REM_W-1:0]   rem_next [2];
  logic [1:0]         mdig     [2];
  logic [OUT_W-1:0]   clamped  [2];

  function automatic frac_t axis_frac(input logic [RAW_W-1:0] raw,
                                      input logic [RAW_W-1:0] lo,
                                      input logic [RAW_W-1:0] hi);
    frac_t            f;
    logic [RAW_W-1:0] c;
    c = raw;
    if (raw < lo) begin
      c = lo;
    end else if (raw > hi) begin
      c = hi;
    end
    if (lo >= hi) begin
      f.n = '0;
      f.d = RAW_W'(1);
    end else begin
      f.n = c - lo;
      f.d = hi - lo;
    end
    return f;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    z1     = {pressure_hi, pressure_lo[BYTE_W-1 -: NIB_W]};
    rx     = {xpos_hi, xpos_lo[BYTE_W-1 -: NIB_W]};
    ry     = {ypos_hi, ypos_lo[BYTE_W-1 -: NIB_W]};
    z_bad  = (pressure_lo[NIB_W-1:0] & NIBBLE_MASK) != '0;
    xy_bad = ((xpos_lo[NIB_W-1:0] | ypos_lo[NIB_W-1:0]) & NIBBLE_MASK) != '0;
    pen_now = was_pressed ? (z1 >= PEN_UP_LEVEL) : (z1 >= PEN_DOWN_LEVEL);

    fx = axis_frac(rx, raw_x_low, raw_x_high);
    fy = axis_frac(ry, raw_y_low, raw_y_high);
    fs[0] = orientation[0] ? fy : fx;
    fs[1] = orientation[0] ? fx : fy;
    fm[0] = fs[0];
    fm[1] = fs[1];
    if (orientation[1]) begin
      fm[0].n = fs[0].d - fs[0].n;
    end
    if (orientation[2]) begin
      fm[1].n = fs[1].d - fs[1].n;
    end

    size[0] = screen_width;
    size[1] = screen_height;
    for (int i = 0; i < 2; i++) begin
      if (size[i] == '0) begin
        lim_in[i] = '0;
      end else if (SIZE_W'(size[i] - SIZE_W'(1)) > SIZE_W'(OUT_MAX)) begin
        lim_in[i] = OUT_MAX;
      end else begin
        lim_in[i] = OUT_W'(size[i] - SIZE_W'(1));
      end
    end

    for (int i = 0; i < 2; i++) begin
      // Multiply MSB digit first: shift the partial product, add n times the digit.
      mdig[i]     = mul_sr[i][QUO_W-1 -: 2];
      acc_next[i] = {acc[i][PROD_W-3:0], 2'b00}
                  + (mdig[i][0] ? PROD_W'(n_reg[i]) : '0)
                  + (mdig[i][1] ? PROD_W'({n_reg[i], 1'b0}) : '0);
      num[i]      = NUM_W'({acc[i], 1'b0}) + NUM_W'(d_reg[i]);

      // Radix-4 restoring divide step against 2*d.
      rem4[i] = {rem[i], low_sr[i][QUO_W-1 -: 2]};
      dm1[i]  = (REM_W+2)'(dvs[i]);
      dm2[i]  = (REM_W+2)'({dvs[i], 1'b0});
      dm3[i]  = dm1[i] + dm2[i];
      if (rem4[i] >= dm3[i]) begin
        qdig[i] = 2'd3;
        sub[i]  = dm3[i];
      end else if (rem4[i] >= dm2[i]) begin
        qdig[i] = 2'd2;
        sub[i]  = dm2[i];
      end else if (rem4[i] >= dm1[i]) begin
        qdig[i] = 2'd1;
        sub[i]  = dm1[i];
      end else begin
        qdig[i] = 2'd0;
        sub[i]  = '0;
      end
      rem_next[i] = REM_W'(rem4[i] - sub[i]);

      clamped[i] = (quo[i] > QUO_W'(limit[i])) ? limit[i] : quo[i][OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      was_pressed   <= 1'b0;
      held_x        <= '0;
      held_y        <= '0;
      raw_x_low     <= '0;
      raw_x_high    <= OUT_MAX;
      raw_y_low     <= '0;
      raw_y_high    <= OUT_MAX;
      orientation   <= '0;
      screen_width  <= SIZE_W'(320);
      screen_height <= SIZE_W'(240);
      cnt           <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_RAW_X_LOW:     raw_x_low     <= cfg_data[RAW_W-1:0];
          CFG_RAW_X_HIGH:    raw_x_high    <= cfg_data[RAW_W-1:0];
          CFG_RAW_Y_LOW:     raw_y_low     <= cfg_data[RAW_W-1:0];
          CFG_RAW_Y_HIGH:    raw_y_high    <= cfg_data[RAW_W-1:0];
          CFG_ORIENTATION:   orientation   <= cfg_data[2:0];
          CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SIZE_W-1:0];
          CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SIZE_W-1:0];
          default: ;
        endcase
      end

      // A result drained while the next one is loaded is handled in S_FIN.
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (bus_error) begin
              res_status <= ST_BUS_ERROR;
              res_pen    <= 1'b0;
              res_x      <= '0;
              res_y      <= '0;
              state      <= S_FIN;
            end else if (z_bad || (pen_now && xy_bad)) begin
              res_status <= ST_BAD_REPLY;
              res_pen    <= 1'b0;
              res_x      <= '0;
              res_y      <= '0;
              state      <= S_FIN;
            end else if (!pen_now) begin
              was_pressed <= 1'b0;
              res_status  <= ST_OK;
              res_pen     <= 1'b0;
              res_x       <= held_x;
              res_y       <= held_y;
              state       <= S_FIN;
            end else begin
              for (int i = 0; i < 2; i++) begin
                n_reg[i]  <= fm[i].n;
                d_reg[i]  <= fm[i].d;
                dvs[i]    <= {fm[i].d, 1'b0};
                mul_sr[i] <= QUO_W'(SIZE_W'(size[i] - SIZE_W'(1)));
                acc[i]    <= '0;
                limit[i]  <= lim_in[i];
              end
              cnt   <= '0;
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          for (int i = 0; i < 2; i++) begin
            acc[i]    <= acc_next[i];
            mul_sr[i] <= {mul_sr[i][QUO_W-3:0], 2'b00};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIGITS - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          // The quotient fits in QUO_W bits, so the upper numerator bits are below 2*d.
          for (int i = 0; i < 2; i++) begin
            rem[i]    <= num[i][NUM_W-2 -: REM_W];
            low_sr[i] <= num[i][QUO_W-1:0];
            quo[i]    <= '0;
          end
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          for (int i = 0; i < 2; i++) begin
            rem[i]    <= rem_next[i];
            low_sr[i] <= {low_sr[i][QUO_W-3:0], 2'b00};
            quo[i]    <= {quo[i][QUO_W-3:0], qdig[i]};
          end
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(DIGITS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          res_status  <= ST_OK;
          res_pen     <= 1'b1;
          res_x       <= clamped[0];
          res_y       <= clamped[1];
          held_x      <= clamped[0];
          held_y      <= clamped[1];
          was_pressed <= 1'b1;
          state       <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status    <= res_status;
            pen_down  <= res_pen;
            screen_x  <= res_x;
            screen_y  <= res_y;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in progress");

  a_pen_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pen_down) |-> (status == ST_OK))
    else $error("pen down reported with an error status");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (!pen_down && screen_x == '0 && screen_y == '0))
    else $error("error result carries coordinates");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ((rem[0] < dvs[0]) && (rem[1] < dvs[1])))
    else $error("divide remainder not below divisor");

  a_x_in_screen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pen_down && screen_width != '0)
      |-> (SIZE_W'(screen_x) < screen_width))
    else $error("mapped X outside the screen width");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the touch pen detect and map block.
`timescale 1ns / 1ps

module testbench
  import tpdm_pkg::*;
();

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_REPORTED  = 10;

  // An index past the last register; writes to it must be dropped.
  localparam cfg_idx_t CFG_UNUSED_INDEX = 3'd7;

  // Bit positions within the orientation register.
  localparam int ORIENT_SWAP     = 0;
  localparam int ORIENT_MIRROR_X = 1;
  localparam int ORIENT_MIRROR_Y = 2;

  typedef struct packed {
    logic              bus_error;
    logic [BYTE_W-1:0] z_hi;
    logic [BYTE_W-1:0] z_lo;
    logic [BYTE_W-1:0] x_hi;
    logic [BYTE_W-1:0] x_lo;
    logic [BYTE_W-1:0] y_hi;
    logic [BYTE_W-1:0] y_lo;
  } touch_sample_t;

  typedef struct packed {
    status_t          st;
    logic             pen;
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] y;
  } touch_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  bus_error = 1'b0;
  logic [BYTE_W-1:0]     pressure_hi = '0;
  logic [BYTE_W-1:0]     pressure_lo = '0;
  logic [BYTE_W-1:0]     xpos_hi = '0;
  logic [BYTE_W-1:0]     xpos_lo = '0;
  logic [BYTE_W-1:0]     ypos_hi = '0;
  logic [BYTE_W-1:0]     ypos_lo = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  status_t               status;
  logic                  pen_down;
  logic [OUT_W-1:0]      screen_x;
  logic [OUT_W-1:0]      screen_y;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the block's calibration and pen state.
  logic [RAW_W-1:0]  cal_x_low = '0;
  logic [RAW_W-1:0]  cal_x_high = 12'd4095;
  logic [RAW_W-1:0]  cal_y_low = '0;
  logic [RAW_W-1:0]  cal_y_high = 12'd4095;
  logic [2:0]        cal_orient = '0;
  logic [SIZE_W-1:0] disp_width = 13'd320;
  logic [SIZE_W-1:0] disp_height = 13'd240;
  logic              pen_held = 1'b0;
  logic [OUT_W-1:0]  last_x = '0;
  logic [OUT_W-1:0]  last_y = '0;

  touch_report_t pending_reports[$];
  touch_report_t got_report;
  touch_report_t want_report;
  int mismatch_count = 0;
  int stall_cycles = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  touch_pen_detect_and_map uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .bus_error  (bus_error),
    .pressure_hi(pressure_hi),
    .pressure_lo(pressure_lo),
    .xpos_hi    (xpos_hi),
    .xpos_lo    (xpos_lo),
    .ypos_hi    (ypos_hi),
    .ypos_lo    (ypos_lo),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .pen_down   (pen_down),
    .screen_x   (screen_x),
    .screen_y   (screen_y),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (rx_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void axis_fraction(input logic [RAW_W-1:0] raw, lo, hi,
                                        output logic [RAW_W-1:0] num, den);
    logic [RAW_W-1:0] clamped;
    if (lo >= hi) begin
      num = '0;
      den = 12'd1;
    end else begin
      clamped = (raw < lo) ? lo : ((raw > hi) ? hi : raw);
      num = clamped - lo;
      den = hi - lo;
    end
  endfunction

  function automatic logic [OUT_W-1:0] scale_to_screen(input logic [RAW_W-1:0] num, den,
                                                       input logic [SIZE_W-1:0] size);
    longint unsigned span;
    longint unsigned q;
    if (size == '0) return '0;
    span = 64'(size) - 64'd1;
    // Round half up: floor((2*n*(S-1) + d) / (2*d)).
    q = (64'(num) * span * 64'd2 + 64'(den)) / (64'(den) * 64'd2);
    if (q > span) q = span;
    if (q > 64'(OUT_MAX)) q = 64'(OUT_MAX);
    return q[OUT_W-1:0];
  endfunction

  function automatic touch_report_t map_touch(input touch_sample_t s);
    touch_report_t r;
    logic [RAW_W-1:0] z1, rx, ry, nx, dx, ny, dy, t;
    logic pressed;
    r = '{st: ST_OK, pen: 1'b0, x: '0, y: '0};
    if (s.bus_error) begin
      r.st = ST_BUS_ERROR;
      return r;
    end
    if (s.z_lo[NIB_W-1:0] != '0) begin
      r.st = ST_BAD_REPLY;
      return r;
    end
    z1 = {s.z_hi, s.z_lo[BYTE_W-1:NIB_W]};
    pressed = pen_held ? (z1 >= PEN_UP_LEVEL) : (z1 >= PEN_DOWN_LEVEL);
    if (!pressed) begin
      pen_held = 1'b0;
      r.x = last_x;
      r.y = last_y;
      return r;
    end
    // Coordinate nibbles only matter once the pen counts as pressed.
    if (s.x_lo[NIB_W-1:0] != '0 || s.y_lo[NIB_W-1:0] != '0) begin
      r.st = ST_BAD_REPLY;
      return r;
    end
    rx = {s.x_hi, s.x_lo[BYTE_W-1:NIB_W]};
    ry = {s.y_hi, s.y_lo[BYTE_W-1:NIB_W]};
    axis_fraction(rx, cal_x_low, cal_x_high, nx, dx);
    axis_fraction(ry, cal_y_low, cal_y_high, ny, dy);
    if (cal_orient[ORIENT_SWAP]) begin
      t = nx; nx = ny; ny = t;
      t = dx; dx = dy; dy = t;
    end
    if (cal_orient[ORIENT_MIRROR_X]) nx = dx - nx;
    if (cal_orient[ORIENT_MIRROR_Y]) ny = dy - ny;
    last_x = scale_to_screen(nx, dx, disp_width);
    last_y = scale_to_screen(ny, dy, disp_height);
    pen_held = 1'b1;
    r.pen = 1'b1;
    r.x = last_x;
    r.y = last_y;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input touch_report_t want, got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED) begin
      $display("%0t: %s: expected status %0d pen %0d x %0d y %0d, got status %0d pen %0d x %0d y %0d",
               $realtime, what, want.st, want.pen, want.x, want.y,
               got.st, got.pen, got.x, got.y);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got_report = '{st: status, pen: pen_down, x: screen_x, y: screen_y};
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected result", '0, got_report);
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report.st !== want_report.st || got_report.pen !== want_report.pen ||
            got_report.x !== want_report.x || got_report.y !== want_report.y) begin
          note_mismatch("result mismatch", want_report, got_report);
        end
      end
    end
  end

  // The watchdog restarts whenever any channel completes a handshake.
  initial begin
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("touch_pen_detect_and_map regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic touch_sample_t make_sample(input logic berr, input logic [RAW_W-1:0] z1,
                                                input logic [RAW_W-1:0] rx, ry,
                                                input logic [NIB_W-1:0] znib = '0,
                                                input logic [NIB_W-1:0] xnib = '0,
                                                input logic [NIB_W-1:0] ynib = '0);
    touch_sample_t s;
    s.bus_error = berr;
    s.z_hi = z1[RAW_W-1:NIB_W];
    s.z_lo = {z1[NIB_W-1:0], znib};
    s.x_hi = rx[RAW_W-1:NIB_W];
    s.x_lo = {rx[NIB_W-1:0], xnib};
    s.y_hi = ry[RAW_W-1:NIB_W];
    s.y_lo = {ry[NIB_W-1:0], ynib};
    return s;
  endfunction

  // Valid is left high after acceptance unless the sender idles; finish_batch
  // lowers it once the last request of a batch has gone.
  task automatic send_sample(input touch_sample_t s);
    int gap;
    in_valid    <= 1'b1;
    bus_error   <= s.bus_error;
    pressure_hi <= s.z_hi;
    pressure_lo <= s.z_lo;
    xpos_hi     <= s.x_hi;
    xpos_lo     <= s.x_lo;
    ypos_hi     <= s.y_hi;
    ypos_lo     <= s.y_lo;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(map_touch(s));
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic finish_batch();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Writes all seven registers plus one ignored index. Only called while idle.
  task automatic set_calibration(input logic [CFG_DATA_W-1:0] xl, xh, yl, yh,
                                 input logic [CFG_DATA_W-1:0] orient, width, height);
    cfg_idx_t             order [8];
    logic [CFG_DATA_W-1:0] vals [8];
    order = '{CFG_RAW_X_LOW, CFG_RAW_X_HIGH, CFG_RAW_Y_LOW, CFG_RAW_Y_HIGH,
              CFG_ORIENTATION, CFG_SCREEN_WIDTH, CFG_SCREEN_HEIGHT, CFG_UNUSED_INDEX};
    vals = '{xl, xh, yl, yh, orient, width, height, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      case (order[i])
        CFG_RAW_X_LOW:     cal_x_low   = vals[i][RAW_W-1:0];
        CFG_RAW_X_HIGH:    cal_x_high  = vals[i][RAW_W-1:0];
        CFG_RAW_Y_LOW:     cal_y_low   = vals[i][RAW_W-1:0];
        CFG_RAW_Y_HIGH:    cal_y_high  = vals[i][RAW_W-1:0];
        CFG_ORIENTATION:   cal_orient  = vals[i][2:0];
        CFG_SCREEN_WIDTH:  disp_width  = vals[i];
        CFG_SCREEN_HEIGHT: disp_height = vals[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic void random_span(output logic [CFG_DATA_W-1:0] lo, hi);
    int pick;
    pick = $urandom_range(19);
    if (pick < 14) begin
      lo = CFG_DATA_W'($urandom_range(1500));
      hi = CFG_DATA_W'($urandom_range(4095, 2500));
    end else if (pick < 17) begin
      // Degenerate span: low at or above high.
      lo = CFG_DATA_W'($urandom_range(4095));
      hi = CFG_DATA_W'($urandom_range(lo));
    end else begin
      lo = CFG_DATA_W'($urandom_range(4095));
      hi = CFG_DATA_W'($urandom_range(4095));
    end
    // The top data bit is outside the register and must be dropped.
    lo[CFG_DATA_W-1] = 1'($urandom_range(1));
    hi[CFG_DATA_W-1] = 1'($urandom_range(1));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_size();
    int pick;
    pick = $urandom_range(19);
    if (pick < 16) return CFG_DATA_W'($urandom_range(4096, 1));
    if (pick < 18) return '0;
    return CFG_DATA_W'($urandom_range(8191, 4097));
  endfunction

  function automatic logic [RAW_W-1:0] near_bound(input logic [RAW_W-1:0] bound);
    int v;
    v = int'(bound) + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[RAW_W-1:0];
  endfunction

  function automatic logic [RAW_W-1:0] random_raw(input logic [RAW_W-1:0] lo, hi);
    int pick;
    pick = $urandom_range(9);
    if (pick < 5) return RAW_W'($urandom_range(4095));
    if (pick < 7) return near_bound(lo);
    if (pick < 9) return near_bound(hi);
    return $urandom_range(1) ? 12'd4095 : 12'd0;
  endfunction

  // Mostly clean samples, many with pressure around the two thresholds, so the
  // hysteresis gets exercised, with some bus errors and bad nibbles mixed in.
  function automatic touch_sample_t random_sample();
    int pick;
    logic [RAW_W-1:0] z1;
    logic [NIB_W-1:0] znib, xnib, ynib;
    pick = $urandom_range(9);
    case (pick)
      0:       z1 = RAW_W'($urandom_range(4095));
      1, 2:    z1 = RAW_W'($urandom_range(210, 190));
      3, 4:    z1 = RAW_W'($urandom_range(90, 70));
      5, 6:    z1 = RAW_W'($urandom_range(4095, 200));
      7, 8:    z1 = RAW_W'($urandom_range(79));
      default: z1 = $urandom_range(1) ? 12'd4095 : 12'd0;
    endcase
    znib = ($urandom_range(99) < 6) ? NIB_W'($urandom_range(15, 1)) : '0;
    xnib = ($urandom_range(99) < 6) ? NIB_W'($urandom_range(15, 1)) : '0;
    ynib = ($urandom_range(99) < 6) ? NIB_W'($urandom_range(15, 1)) : '0;
    return make_sample($urandom_range(99) < 5, z1,
                       random_raw(cal_x_low, cal_x_high),
                       random_raw(cal_y_low, cal_y_high), znib, xnib, ynib);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Runs on the reset calibration: hysteresis edges, held coordinates and
  // every error status, including bus error winning over a bad nibble.
  task automatic test_pen_hysteresis_and_errors();
    send_sample(make_sample(1'b0, 12'd4095, 12'd0, 12'd4095));
    send_sample(make_sample(1'b0, 12'd80, 12'd4095, 12'd0));
    send_sample(make_sample(1'b0, 12'd79, 12'd1234, 12'd777));
    send_sample(make_sample(1'b0, 12'd199, 12'd100, 12'd100, 4'h0, 4'hF, 4'h1));
    send_sample(make_sample(1'b0, 12'd200, 12'd2048, 12'd2048));
    send_sample(make_sample(1'b1, 12'd4095, 12'd10, 12'd10, 4'hF));
    send_sample(make_sample(1'b0, 12'd4095, 12'd10, 12'd10, 4'h8));
    send_sample(make_sample(1'b0, 12'd300, 12'd10, 12'd10, 4'h0, 4'h0, 4'h1));
    send_sample(make_sample(1'b0, 12'd100, 12'd4095, 12'd4095));
    send_sample('1);
    send_sample('0);
    send_sample(make_sample(1'b0, 12'd0, 12'd0, 12'd0, 4'h0, 4'h0, 4'hF));
    finish_batch();
  endtask

  // Register extremes: masked data, degenerate spans in both directions, zero
  // and oversized screens, and every orientation bit.
  task automatic test_calibration_extremes();
    set_calibration(13'h1064, 13'd4000, 13'd500, 13'd500, 13'h1FFF, 13'd8191, 13'd0);
    send_sample(make_sample(1'b0, 12'd4095, 12'd0, 12'd0));
    send_sample(make_sample(1'b0, 12'd4095, 12'd2000, 12'd4095));
    send_sample(make_sample(1'b0, 12'd4095, 12'd4095, 12'd123));
    finish_batch();
    set_calibration(13'd0, 13'd4095, 13'd0, 13'd4095, 13'd1, 13'd1, 13'd4096);
    send_sample(make_sample(1'b0, 12'd4095, 12'd4095, 12'd1));
    send_sample(make_sample(1'b0, 12'd4095, 12'd2047, 12'd4095));
    finish_batch();
    set_calibration(13'd4095, 13'd0, 13'd0, 13'd4095, 13'd6, 13'd4096, 13'd1);
    send_sample(make_sample(1'b0, 12'd4095, 12'd3000, 12'd0));
    send_sample(make_sample(1'b0, 12'd4095, 12'd3000, 12'd2048));
    finish_batch();
  endtask

  task automatic test_random_traffic();
    logic [CFG_DATA_W-1:0] xl, xh, yl, yh;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 27; rx_idle_pct = 50; end
        1:       begin tx_idle_pct = 50; rx_idle_pct = 27; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        random_span(xl, xh);
        random_span(yl, yh);
        set_calibration(xl, xh, yl, yh, CFG_DATA_W'($urandom_range(7)),
                        random_size(), random_size());
        for (int i = 0; i < 45; i++) send_sample(random_sample());
        finish_batch();
      end
    end
  endtask

  initial begin
    tx_idle_pct = 27;
    rx_idle_pct = 50;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pen_hysteresis_and_errors();
    test_calibration_extremes();
    test_random_traffic();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("touch_pen_detect_and_map regression: pass");
    end else begin
      $display("touch_pen_detect_and_map regression: fail");
    end
    $finish;
  end

endmodule

### touch_pen_detect_and_map.f
hw/rtl/tpdm_pkg.sv
hw/rtl/touch_pen_detect_and_map.sv
tb/testbench.sv
